>>> rtl/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg
// Types, constants and round tables shared by the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package shs_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int BLOCK_BITS  = BLOCK_BYTES * 8;
    localparam int ROUNDS      = 64;
    localparam int CHAIN_WORDS = 8;
    localparam int SCHED_WORDS = 16;

    localparam logic [7:0] PAD_MARK = 8'h80;
    // last byte position that still leaves room for the length field
    localparam logic [5:0] PAD_LAST_FIT = 6'd55;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LOAD,
        S_WAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic start;   // load block and chain, begin 64 rounds
        logic init;    // return chain words to the initial hash
    } t_core_ctl;

    typedef struct packed {
        logic busy;
        logic done;    // chain words updated at this edge
    } t_core_sts;

    localparam logic [31:0] H_INIT [CHAIN_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TABLE [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

>>> rtl/shs_core.sv
// ----------------------------------------------------------------------------
// shs_core
// SHA-256 compression unit: one round per cycle for 64 rounds, rolling
// 16-word message schedule, chaining words updated in a final add step.
// ----------------------------------------------------------------------------
module shs_core
    import shs_pkg::*;
(
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  t_core_ctl                          i_ctl,
    input  logic [BLOCK_BITS-1:0]              i_block,
    output t_core_sts                          o_sts,
    output logic [CHAIN_WORDS-1:0][31:0]       o_chain
);

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    logic [31:0] r_h [CHAIN_WORDS];
    logic [31:0] r_v [CHAIN_WORDS];
    logic [31:0] r_w [SCHED_WORDS];
    logic [5:0]  r_rnd;
    logic        r_run;
    logic        r_add;

    logic [31:0] big_s0, big_s1, ch, maj, t1, t2;
    logic [31:0] sm_s0, sm_s1, w_new;

    always_comb begin
        big_s1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        big_s0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        ch     = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        maj    = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1     = r_v[7] + big_s1 + ch + K_TABLE[r_rnd] + r_w[0];
        t2     = big_s0 + maj;
        sm_s0  = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        sm_s1  = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new  = sm_s1 + r_w[9] + sm_s0 + r_w[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_add <= 1'b0;
            r_rnd <= '0;
            for (int i = 0; i < CHAIN_WORDS; i++) begin
                r_h[i] <= H_INIT[i];
            end
        end else if (i_ctl.init) begin
            for (int i = 0; i < CHAIN_WORDS; i++) begin
                r_h[i] <= H_INIT[i];
            end
        end else if (i_ctl.start) begin
            for (int i = 0; i < CHAIN_WORDS; i++) begin
                r_v[i] <= r_h[i];
            end
            for (int i = 0; i < SCHED_WORDS; i++) begin
                r_w[i] <= i_block[BLOCK_BITS-1-32*i -: 32];
            end
            r_rnd <= '0;
            r_run <= 1'b1;
        end else if (r_run) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
            // window always presents the current round's word at index 0
            for (int i = 0; i < SCHED_WORDS - 1; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[SCHED_WORDS-1] <= w_new;
            r_rnd <= r_rnd + 6'd1;
            if (r_rnd == 6'(ROUNDS - 1)) begin
                r_run <= 1'b0;
                r_add <= 1'b1;
            end
        end else if (r_add) begin
            for (int i = 0; i < CHAIN_WORDS; i++) begin
                r_h[i] <= r_h[i] + r_v[i];
            end
            r_add <= 1'b0;
        end
    end

    always_comb begin
        o_sts.busy = r_run | r_add;
        o_sts.done = r_add;
        for (int i = 0; i < CHAIN_WORDS; i++) begin
            o_chain[i] = r_h[i];
        end
    end

endmodule

>>> rtl/sha256_stream_hasher_unit.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit
// Byte-stream SHA-256: packs bytes into blocks, pads, emits the digest.
// ----------------------------------------------------------------------------
// Message bytes are taken one item per cycle while a block fills. The 64th
// byte of a block starts the compression unit, which runs one round per
// cycle through a load, the rounds and a chain update, during which no
// item is taken. An item with end_of_message set starts padding, which
// shifts one pad or length byte per cycle into the block buffer until the
// block is full, then compresses; when fewer than nine bytes were free a
// second padded block follows. The digest then leaves as eight items,
// word 0 first, one per cycle when the output is not stalled; no input
// item is taken until the eighth word has gone.
module sha256_stream_hasher_unit
    import shs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_state                        r_state, n_state;
    logic [BLOCK_BITS-1:0]         r_buf;
    logic [5:0]                    r_fill, n_fill;
    logic [28:0]                   r_total, n_total;
    logic                          r_fin, n_fin;
    logic                          r_marked, n_marked;
    logic                          r_two, n_two;
    logic                          r_final, n_final;
    logic [2:0]                    r_idx, n_idx;

    logic                          shift_en;
    logic [7:0]                    shift_byte;
    logic                          in_acc, out_acc;
    logic                          two_eff;
    logic [31:0]                   bit_count;
    t_core_ctl                     core_ctl;
    t_core_sts                     core_sts;
    logic [CHAIN_WORDS-1:0][31:0]  chain;

    shs_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .i_block (r_buf),
        .o_sts   (core_sts),
        .o_chain (chain)
    );

    assign in_acc    = i_in_valid && !o_in_stall;
    assign out_acc   = o_out_valid && !i_out_stall;
    assign bit_count = {r_total, 3'b000};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_total  <= '0;
            r_fin    <= 1'b0;
            r_marked <= 1'b0;
            r_two    <= 1'b0;
            r_final  <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_total  <= n_total;
            r_fin    <= n_fin;
            r_marked <= n_marked;
            r_two    <= n_two;
            r_final  <= n_final;
            r_idx    <= n_idx;
        end
    end

    // block buffer: byte 0 of the block ends up in the top bits
    always_ff @(posedge i_clk) begin
        if (shift_en) begin
            r_buf <= {r_buf[BLOCK_BITS-9:0], shift_byte};
        end
    end

    always_comb begin
        n_state       = r_state;
        n_fill        = r_fill;
        n_total       = r_total;
        n_fin         = r_fin;
        n_marked      = r_marked;
        n_two         = r_two;
        n_final       = r_final;
        n_idx         = r_idx;
        shift_en      = 1'b0;
        shift_byte    = i_in_item.data_byte;
        core_ctl      = '0;
        o_in_stall    = 1'b1;
        o_out_valid   = 1'b0;
        two_eff       = r_marked ? r_two : (r_fill > PAD_LAST_FIT);

        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (in_acc) begin
                    n_fin    = i_in_item.end_of_message;
                    n_marked = 1'b0;
                    n_two    = 1'b0;
                    n_final  = 1'b0;
                    if (i_in_item.byte_valid) begin
                        shift_en = 1'b1;
                        n_fill   = r_fill + 6'd1;
                        n_total  = r_total + 29'd1;
                    end
                    if (i_in_item.byte_valid && r_fill == 6'(BLOCK_BYTES - 1)) begin
                        n_state = S_LOAD;
                    end else if (i_in_item.end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                shift_en = 1'b1;
                n_fill   = r_fill + 6'd1;
                if (!r_marked) begin
                    shift_byte = PAD_MARK;
                    n_marked   = 1'b1;
                    n_two      = two_eff;
                end else if (!r_two && r_fill[5:2] == 4'hF) begin
                    // length field, big-endian in the last four bytes
                    case (r_fill[1:0])
                        2'd0:    shift_byte = bit_count[31:24];
                        2'd1:    shift_byte = bit_count[23:16];
                        2'd2:    shift_byte = bit_count[15:8];
                        default: shift_byte = bit_count[7:0];
                    endcase
                end else begin
                    shift_byte = 8'h00;
                end
                if (r_fill == 6'(BLOCK_BYTES - 1)) begin
                    n_final = !two_eff;
                    n_two   = 1'b0;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                core_ctl.start = !core_sts.busy;
                if (!core_sts.busy) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (core_sts.done) begin
                    if (!r_fin) begin
                        n_state = S_IDLE;
                    end else if (r_final) begin
                        n_idx   = '0;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_PAD;
                    end
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (out_acc) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'(CHAIN_WORDS - 1)) begin
                        core_ctl.init = 1'b1;
                        n_total       = '0;
                        n_fill        = '0;
                        n_fin         = 1'b0;
                        n_state       = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_out_item.digest_word = chain[r_idx];
        o_out_item.word_index  = r_idx;
        o_out_item.last_word   = (r_idx == 3'(CHAIN_WORDS - 1));
    end

`ifndef SYNTH
    a_no_input_while_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while digest pending");

    a_fill_empty_at_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_fill == '0))
        else $error("digest emitted with bytes left in block");

    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_ctl.start |-> !core_sts.busy)
        else $error("compression started while busy");

    a_clear_after_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_out_item.last_word) |=> (r_total == '0 && r_state == S_IDLE))
        else $error("message state not cleared after digest");
`endif

endmodule
